### design/mma_pkg.sv
package mma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = 3;
  localparam int CFG_W    = 7;
  localparam int USER_W   = CHAN_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STATE,
    ST_HIST,
    ST_DIV,
    ST_DONE
  } mma_state_t;

endpackage

### design/mma_div.sv
module mma_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic        [DIVISOR_W-1:0]  divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;

  assign rem_sh = {rem_r, q_r[DIVIDEND_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      q_nxt    = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem_nxt  = '0;
      neg_nxt  = dividend[DIVIDEND_W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? DIVISOR_W'(rem_sh - {1'b0, divisor}) : DIVISOR_W'(rem_sh);
      q_nxt   = {q_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

### design/multichannel_moving_average_unit.sv
// Boxcar moving average over interleaved channels.
// Input channel: in_tdata carries the signed sample, in_tuser the channel number
// and the series start flag. Each accepted transfer yields exactly one result
// transfer on the out_ channel: the raw sample while the channel warms up
// (averaged flag 0), then the window sum divided by the window length,
// truncated toward zero (averaged flag 1).
// cfg_we/cfg_wdata set the window length (0 counts as 1, values above
// MAX_WINDOW saturate); a write restarts the warm-up on every channel.
// A pass-through result for a channel below CHANNELS passes the states ST_STATE
// and ST_HIST before ST_DONE; one for a channel at or above CHANNELS goes
// straight to ST_DONE. An averaged result also passes ST_DIV, where the
// bit-serial divider produces one quotient bit per cycle. The next item is taken
// once the result has moved into the output register. Per-channel sums, fill
// counts and write slots sit in a state memory read at acceptance (ST_IDLE) and
// written back in ST_HIST; the sample history sits in a second memory read in
// ST_STATE, the cycle before the write-back. One item is in flight at a time and
// the next item is taken while the result still waits; a stalled receiver holds
// the output register and the item behind it. Reset clears all channel state at
// once; no clearing pass.
module multichannel_moving_average_unit
  import mma_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int CHANNELS   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // sample
  input  logic [USER_W-1:0]   in_tuser,   // channel, series_start
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,  // value
  output logic [USER_W-1:0]   out_tuser,  // out_channel, averaged
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int W_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int HDEPTH    = CHANNELS * MAX_WINDOW;
  localparam int HA_W      = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int RESET_WIN = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [W_W-1:0]          fill;
    logic [SLOT_W-1:0]       slot;
  } chst_t;

  mma_state_t state_r, state_nxt;

  logic [W_W-1:0]             win_r;
  logic [CHANNELS-1:0]        series_vld_r;
  logic [CHANNELS-1:0]        slot_vld_r;

  chst_t                      st_mem [CHANNELS];
  chst_t                      st_rdata_r;
  logic signed [SAMPLE_W-1:0] hist_mem [HDEPTH];
  logic signed [SAMPLE_W-1:0] hist_rdata_r;

  logic [CHAN_W-1:0]          ch_r;
  logic [CH_W-1:0]            idx_r;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic                       start_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [W_W-1:0]             fill_r;
  logic [SLOT_W-1:0]          slot_r;
  logic                       full_r;
  logic [SAMPLE_W-1:0]        res_r;
  logic                       avg_r;

  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;
  logic [USER_W-1:0]          out_user_r;

  logic                       in_xfer;
  logic                       in_range;
  logic                       st_re, hist_re, wr_back, div_start, load_out;
  logic                       out_free;

  logic                       cur_sv;
  logic signed [SUM_W-1:0]    cur_sum;
  logic [W_W-1:0]             cur_fill;
  logic [SLOT_W-1:0]          cur_slot;
  logic                       cur_full;
  logic [W_W:0]               old_tmp;
  logic [SLOT_W-1:0]          old_slot;
  logic [HA_W-1:0]            hist_raddr;
  logic [HA_W-1:0]            hist_waddr;

  logic signed [SUM_W-1:0]    new_sum;
  logic [W_W-1:0]             new_fill;
  logic [SLOT_W-1:0]          new_slot;
  logic                       new_avg;
  chst_t                      st_wdata;

  logic                       div_done;
  logic signed [SUM_W-1:0]    div_q;
  logic [W_W-1:0]             cfg_win;

  assign in_range = 32'(in_tuser[CHAN_W-1:0]) < CHANNELS;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_range ? ST_STATE : ST_DONE;
        end
      end
      ST_STATE: state_nxt = ST_HIST;
      ST_HIST:  state_nxt = new_avg ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    st_re     = 1'b0;
    hist_re   = 1'b0;
    wr_back   = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        st_re     = in_tvalid && in_range;
      end
      ST_STATE: hist_re = 1'b1;
      ST_HIST: begin
        wr_back   = 1'b1;
        div_start = new_avg;
      end
      ST_DIV:  ;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // window length
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_win = W_W'(1);
    end else if (32'(cfg_wdata) > MAX_WINDOW) begin
      cfg_win = W_W'(MAX_WINDOW);
    end else begin
      cfg_win = W_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= W_W'(RESET_WIN);
      series_vld_r <= '0;
      slot_vld_r   <= '0;
    end else begin
      if (cfg_we) begin
        win_r        <= cfg_win;
        series_vld_r <= '0;
      end
      if (wr_back) begin
        series_vld_r[idx_r] <= 1'b1;
        slot_vld_r[idx_r]   <= 1'b1;
      end
    end
  end

  // channel state read
  always_comb begin
    cur_sv   = series_vld_r[idx_r] && !start_r;
    cur_sum  = cur_sv ? st_rdata_r.sum : '0;
    cur_fill = cur_sv ? st_rdata_r.fill : '0;
    cur_slot = slot_vld_r[idx_r] ? st_rdata_r.slot : '0;
    cur_full = cur_fill >= win_r;
    old_tmp  = (W_W+1)'(cur_slot) + (W_W+1)'(MAX_WINDOW) - (W_W+1)'(win_r);
    if (old_tmp >= (W_W+1)'(MAX_WINDOW)) begin
      old_slot = SLOT_W'(old_tmp - (W_W+1)'(MAX_WINDOW));
    end else begin
      old_slot = SLOT_W'(old_tmp);
    end
    hist_raddr = HA_W'(idx_r) * HA_W'(MAX_WINDOW) + HA_W'(old_slot);
  end

  // update
  always_comb begin
    new_sum  = sum_r - (full_r ? SUM_W'(hist_rdata_r) : SUM_W'(0)) + SUM_W'(smp_r);
    new_fill = full_r ? fill_r : fill_r + W_W'(1);
    new_avg  = new_fill >= win_r;
    if (slot_r == SLOT_W'(MAX_WINDOW - 1)) begin
      new_slot = '0;
    end else begin
      new_slot = slot_r + SLOT_W'(1);
    end
    st_wdata.sum  = new_sum;
    st_wdata.fill = new_fill;
    st_wdata.slot = new_slot;
    hist_waddr    = HA_W'(idx_r) * HA_W'(MAX_WINDOW) + HA_W'(slot_r);
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      st_rdata_r <= st_mem[CH_W'(in_tuser[CHAN_W-1:0])];
    end
    if (wr_back) begin
      st_mem[idx_r] <= st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_re) begin
      hist_rdata_r <= hist_mem[hist_raddr];
    end
    if (wr_back) begin
      hist_mem[hist_waddr] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch_r    <= in_tuser[CHAN_W-1:0];
      idx_r   <= CH_W'(in_tuser[CHAN_W-1:0]);
      smp_r   <= in_tdata;
      start_r <= in_tuser[CHAN_W];
      res_r   <= in_tdata;
      avg_r   <= 1'b0;
    end
    if (hist_re) begin
      sum_r  <= cur_sum;
      fill_r <= cur_fill;
      slot_r <= cur_slot;
      full_r <= cur_full;
    end
    if (wr_back) begin
      res_r <= smp_r;
      avg_r <= 1'b0;
    end
    if (state_r == ST_DIV && div_done) begin
      res_r <= div_q[SAMPLE_W-1:0];
      avg_r <= 1'b1;
    end
  end

  mma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (W_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_data_r <= res_r;
      out_user_r <= {avg_r, ch_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
